>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/frg_pkg.sv
package frg_pkg;

    localparam int DATA_WIDTH = 31;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    localparam cnt_t LAST_BIT = CNT_W'(DATA_WIDTH - 1);

endpackage

>>> rtl/frg_divider.sv
module frg_divider (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  frg_pkg::data_t dividend,
    input  frg_pkg::data_t divisor,
    output logic          done,
    output frg_pkg::data_t quotient,
    output frg_pkg::data_t remainder
);
    import frg_pkg::*;

    // Restoring division, one quotient bit per cycle. The dividend shifts
    // out of the top of quot_reg while quotient bits shift in at the bottom.
    logic                  running_reg, running_next;
    logic                  done_reg, done_next;
    cnt_t                  cnt_reg, cnt_next;
    data_t                 rem_reg, rem_next;
    data_t                 quot_reg, quot_next;
    data_t                 dvs_reg, dvs_next;
    logic [DATA_WIDTH:0]   rem_shift;
    logic [DATA_WIDTH:0]   rem_diff;

    always_comb
    begin
        rem_shift    = {rem_reg, quot_reg[DATA_WIDTH-1]};
        rem_diff     = rem_shift - {1'b0, dvs_reg};
        running_next = running_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        dvs_next     = dvs_reg;
        if (start)
        begin
            running_next = 1'b1;
            cnt_next     = '0;
            rem_next     = '0;
            quot_next    = dividend;
            dvs_next     = divisor;
        end
        else if (running_reg)
        begin
            if (!rem_diff[DATA_WIDTH])
            begin
                rem_next  = rem_diff[DATA_WIDTH-1:0];
                quot_next = {quot_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[DATA_WIDTH-1:0];
                quot_next = {quot_reg[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + cnt_t'(1);
            if (cnt_reg == LAST_BIT)
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/fraction_reduce_gcd.sv
// Channel   Handshake       Words
// input     start / busy    numer_in, denom_in
// result    done (strobe)   numer_out, denom_out, common_divisor, div_error
//
// One word is handled at a time; busy stays high from acceptance until the
// result strobe. Every remainder step and both final divisions run on one
// shared bit-serial divider, so a word takes (steps + 2) divisions.
// A zero denominator is answered straight from CHECK, with no division.
// Reset clears the sequencer and the strobe; the receiver cannot stall.
module fraction_reduce_gcd (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  frg_pkg::data_t numer_in,
    input  frg_pkg::data_t denom_in,
    output logic           done,
    output frg_pkg::data_t numer_out,
    output frg_pkg::data_t denom_out,
    output frg_pkg::data_t common_divisor,
    output logic           div_error
);
    import frg_pkg::*;

`include "assert_macros.svh"

    // Sequencer states. CHECK decides the next Euclid step; MOD, DIVN and DIVD
    // wait for the shared divider to finish.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_DIVN  = 3'd3;
    localparam logic [2:0] ST_DIVD  = 3'd4;

    logic [2:0] state_reg, state_next;

    // Euclid operands a and b, the original fraction, and the quotient of the
    // numerator once it is known.
    data_t a_reg, a_next;
    data_t b_reg, b_next;
    data_t n_reg, n_next;
    data_t d_reg, d_next;
    data_t qn_reg, qn_next;

    logic  done_reg, done_next;
    data_t numer_out_reg, numer_out_next;
    data_t denom_out_reg, denom_out_next;
    data_t gcd_out_reg, gcd_out_next;
    logic  err_reg, err_next;

    logic  div_start;
    data_t div_dividend;
    data_t div_divisor;
    logic  div_done;
    data_t div_quot;
    data_t div_rem;

    frg_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        qn_next        = qn_reg;
        done_next      = 1'b0;
        numer_out_next = numer_out_reg;
        denom_out_next = denom_out_reg;
        gcd_out_next   = gcd_out_reg;
        err_next       = err_reg;
        div_start      = 1'b0;
        div_dividend   = a_reg;
        div_divisor    = b_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_next     = numer_in;
                    b_next     = denom_in;
                    n_next     = numer_in;
                    d_next     = denom_in;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (b_reg == '0)
                begin
                    // Zero denominator: pass the fraction through and flag it.
                    done_next      = 1'b1;
                    numer_out_next = n_reg;
                    denom_out_next = '0;
                    gcd_out_next   = '0;
                    err_next       = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (a_reg == '0)
                begin
                    // b holds the divisor; reduce the numerator first.
                    div_start    = 1'b1;
                    div_dividend = n_reg;
                    div_divisor  = b_reg;
                    state_next   = ST_DIVN;
                end
                else
                begin
                    // Swap when a is the smaller operand, then take a mod b.
                    div_start = 1'b1;
                    if (a_reg < b_reg)
                    begin
                        a_next       = b_reg;
                        b_next       = a_reg;
                        div_dividend = b_reg;
                        div_divisor  = a_reg;
                    end
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (div_done)
                begin
                    a_next     = div_rem;
                    state_next = ST_CHECK;
                end
            end
            ST_DIVN:
            begin
                if (div_done)
                begin
                    qn_next      = div_quot;
                    div_start    = 1'b1;
                    div_dividend = d_reg;
                    div_divisor  = b_reg;
                    state_next   = ST_DIVD;
                end
            end
            ST_DIVD:
            begin
                if (div_done)
                begin
                    done_next      = 1'b1;
                    numer_out_next = qn_reg;
                    denom_out_next = div_quot;
                    gcd_out_next   = b_reg;
                    err_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        n_reg         <= n_next;
        d_reg         <= d_next;
        qn_reg        <= qn_next;
        numer_out_reg <= numer_out_next;
        denom_out_reg <= denom_out_next;
        gcd_out_reg   <= gcd_out_next;
        err_reg       <= err_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign numer_out      = numer_out_reg;
    assign denom_out      = denom_out_reg;
    assign common_divisor = gcd_out_reg;
    assign div_error      = err_reg;

    // The result strobe comes only once the sequencer is back at rest.
    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done, !busy, "result strobe while busy")
    // An accepted word always makes the block busy in the next cycle.
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word not taken")
    // A good result carries a nonzero divisor, an error result a zero one.
    `ASSERT_IMPLIES(a_gcd_nonzero, clk, rst_n, done && !div_error,
        common_divisor != '0, "zero divisor on a good result")
    `ASSERT_IMPLIES(a_err_gcd_zero, clk, rst_n, done && div_error,
        common_divisor == '0 && denom_out == '0, "error result with nonzero fields")

endmodule
